// ----- src/priority_job_queue_macros.svh -----
// Assertion helpers for the checker file of priority_job_queue.
`ifndef PRIORITY_JOB_QUEUE_MACROS_SVH
`define PRIORITY_JOB_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PJQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define PJQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- src/pjq_pkg.sv -----
// ----------------------------------------------------------------------------
// pjq_pkg
// Shared types, sizes, command and status codes of the priority job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pjq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TICK_W      = 8;

   localparam logic [TICK_W-1:0] INTERVAL_RESET = 8'd20;

   // Input commands
   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_REMOVE  = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // Result status codes
   localparam logic [3:0] ST_ADDED        = 4'd0;
   localparam logic [3:0] ST_REMOVED      = 4'd1;
   localparam logic [3:0] ST_PRINTED      = 4'd2;
   localparam logic [3:0] ST_WAITING      = 4'd3;
   localparam logic [3:0] ST_TICK_EMPTY   = 4'd4;
   localparam logic [3:0] ST_FULL         = 4'd5;
   localparam logic [3:0] ST_DUPLICATE    = 4'd6;
   localparam logic [3:0] ST_NOT_FOUND    = 4'd7;
   localparam logic [3:0] ST_REMOVE_EMPTY = 4'd8;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] job_id;
      logic [1:0]  job_kind;
      logic [1:0]  job_priority;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] out_id;
      logic [1:0]  out_kind;
      logic [1:0]  out_priority;
      logic [4:0]  occupancy;
   } rsp_payload_type;

   // Controller to datapath: one decoded operation per transfer
   typedef struct packed {
      logic exec;
      logic enq;
      logic rem;
      logic tick;
   } ctrl_cmd_type;

   // Port id to stored id: truncate or zero-extend to ID_BITS
   function automatic logic [ID_BITS-1:0] to_stored_id(input logic [15:0] id);
      logic [ID_BITS+15:0] wide;
      wide = {{ID_BITS{1'b0}}, id};
      return wide[ID_BITS-1:0];
   endfunction

   // Stored id to port id: low 16 bits
   function automatic logic [15:0] to_port_id(input logic [ID_BITS-1:0] id);
      logic [ID_BITS+15:0] wide;
      wide = {16'h0000, id};
      return wide[15:0];
   endfunction

   function automatic logic [4:0] to_occupancy(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+4:0] wide;
      wide = {5'b00000, cnt};
      return wide[4:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/priority_job_queue.sv -----
// ----------------------------------------------------------------------------
// priority_job_queue
// Three-level priority job queue with remove by id and timed printing.
// ----------------------------------------------------------------------------
// Each request (enqueue, remove by id, tick) is executed in the cycle of its
// transfer and gives exactly one response in the next cycle, held in an output
// register. A new request is taken in every cycle that the response register
// is empty or being drained, so the block sustains one item per cycle; all
// sixteen queue entries are compared in parallel and the queue shifts as a
// whole. print_interval is written through csr_wr_en / csr_wr_data (reset 20).
`default_nettype none

module priority_job_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire pjq_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output pjq_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_wr_en,
   input  wire logic [7:0]               csr_wr_data
);
   import pjq_pkg::*;

   ctrl_cmd_type cmd;

   pjq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_payload.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   pjq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req         (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- src/pjq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pjq_ctrl
// Handshake controller: accepts a request when the result register is free
// or being drained, and decodes the command for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_command,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output pjq_pkg::ctrl_cmd_type         cmd
);
   import pjq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic xfer;

   // hold off requests while reset is high
   assign req_ready = !reset && ((state_ff == S_IDLE) || rsp_ready);
   assign xfer      = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_HOLD);

   always_comb begin
      cmd      = '0;
      cmd.exec = xfer;
      case (req_command)
         CMD_ENQUEUE: cmd.enq  = xfer;
         CMD_REMOVE:  cmd.rem  = xfer;
         CMD_TICK:    cmd.tick = xfer;
         default:     ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (xfer) state_in = S_HOLD;
         end
         S_HOLD: begin
            // a new transfer refills the result register as it drains
            if (!xfer && rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pjq_datapath.sv -----
// ----------------------------------------------------------------------------
// pjq_datapath
// Sorted shift-register queue with parallel id and priority compare, tick
// counter, interval register and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pjq_pkg::ctrl_cmd_type    cmd,
   input  wire pjq_pkg::req_payload_type req,
   input  wire logic                     csr_wr_en,
   input  wire logic [7:0]               csr_wr_data,
   output pjq_pkg::rsp_payload_type      rsp
);
   import pjq_pkg::*;

   logic [ID_BITS-1:0] id_ff   [QUEUE_DEPTH];
   logic [ID_BITS-1:0] id_in   [QUEUE_DEPTH];
   logic [1:0]         kind_ff [QUEUE_DEPTH];
   logic [1:0]         kind_in [QUEUE_DEPTH];
   logic [1:0]         prio_ff [QUEUE_DEPTH];
   logic [1:0]         prio_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  interval_ff;
   rsp_payload_type    rsp_ff, rsp_in;

   // neighbor views for shifting up (insert) and down (remove)
   logic [ID_BITS-1:0] prev_id   [QUEUE_DEPTH];
   logic [1:0]         prev_kind [QUEUE_DEPTH];
   logic [1:0]         prev_prio [QUEUE_DEPTH];
   logic [ID_BITS-1:0] next_id   [QUEUE_DEPTH];
   logic [1:0]         next_kind [QUEUE_DEPTH];
   logic [1:0]         next_prio [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0] valid, match, seen, first, ins, ins_prev;
   logic [ID_BITS-1:0]     req_id, sel_id;
   logic [1:0]             req_prio, sel_kind, sel_prio;
   logic                   dup, full, empty, fire;

   always_comb begin
      req_id   = to_stored_id(req.job_id);
      // priority zero saturates to the highest level
      req_prio = (req.job_priority == 2'd0) ? 2'd1 : req.job_priority;

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid[i] = CNT_W'(i) < count_ff;
         match[i] = valid[i] && (id_ff[i] == req_id);
         ins[i]   = !(valid[i] && (prio_ff[i] <= req_prio));
      end

      seen[0] = match[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         seen[i] = seen[i-1] | match[i];
      end

      first[0]    = match[0];
      ins_prev[0] = 1'b0;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         first[i]    = match[i] & ~seen[i-1];
         ins_prev[i] = ins[i-1];
      end

      prev_id[0]   = req_id;
      prev_kind[0] = req.job_kind;
      prev_prio[0] = req_prio;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         prev_id[i]   = id_ff[i-1];
         prev_kind[i] = kind_ff[i-1];
         prev_prio[i] = prio_ff[i-1];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         next_id[i]   = id_ff[i+1];
         next_kind[i] = kind_ff[i+1];
         next_prio[i] = prio_ff[i+1];
      end
      next_id[QUEUE_DEPTH-1]   = id_ff[QUEUE_DEPTH-1];
      next_kind[QUEUE_DEPTH-1] = kind_ff[QUEUE_DEPTH-1];
      next_prio[QUEUE_DEPTH-1] = prio_ff[QUEUE_DEPTH-1];

      sel_id   = '0;
      sel_kind = '0;
      sel_prio = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (first[i]) begin
            sel_id   = sel_id   | id_ff[i];
            sel_kind = sel_kind | kind_ff[i];
            sel_prio = sel_prio | prio_ff[i];
         end
      end

      dup   = |match;
      full  = count_ff >= CNT_W'(QUEUE_DEPTH);
      empty = count_ff == '0;
      fire  = ({1'b0, tick_ff} + 9'd1) >= {1'b0, interval_ff};
   end

   always_comb begin
      id_in    = id_ff;
      kind_in  = kind_ff;
      prio_in  = prio_ff;
      count_in = count_ff;
      tick_in  = tick_ff;
      rsp_in   = '0;
      rsp_in.status = ST_WAITING;

      if (cmd.enq) begin
         if (dup) begin
            rsp_in.status = ST_DUPLICATE;
         end else if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            // insert after every entry of equal or higher priority
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (ins[i]) begin
                  if (ins_prev[i]) begin
                     id_in[i]   = prev_id[i];
                     kind_in[i] = prev_kind[i];
                     prio_in[i] = prev_prio[i];
                  end else begin
                     id_in[i]   = req_id;
                     kind_in[i] = req.job_kind;
                     prio_in[i] = req_prio;
                  end
               end
            end
            count_in            = count_ff + CNT_W'(1);
            rsp_in.status       = ST_ADDED;
            rsp_in.out_id       = to_port_id(req_id);
            rsp_in.out_kind     = req.job_kind;
            rsp_in.out_priority = req_prio;
         end
      end else if (cmd.rem) begin
         if (empty) begin
            rsp_in.status = ST_REMOVE_EMPTY;
         end else if (!dup) begin
            rsp_in.status = ST_NOT_FOUND;
         end else begin
            // close the gap from the first match upward
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (seen[i]) begin
                  id_in[i]   = next_id[i];
                  kind_in[i] = next_kind[i];
                  prio_in[i] = next_prio[i];
               end
            end
            count_in            = count_ff - CNT_W'(1);
            rsp_in.status       = ST_REMOVED;
            rsp_in.out_id       = to_port_id(sel_id);
            rsp_in.out_kind     = sel_kind;
            rsp_in.out_priority = sel_prio;
         end
      end else if (cmd.tick) begin
         if (!fire) begin
            tick_in = tick_ff + TICK_W'(1);
         end else begin
            tick_in = '0;
            if (empty) begin
               rsp_in.status = ST_TICK_EMPTY;
            end else begin
               // dequeue the head
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  id_in[i]   = next_id[i];
                  kind_in[i] = next_kind[i];
                  prio_in[i] = next_prio[i];
               end
               count_in            = count_ff - CNT_W'(1);
               rsp_in.status       = ST_PRINTED;
               rsp_in.out_id       = to_port_id(id_ff[0]);
               rsp_in.out_kind     = kind_ff[0];
               rsp_in.out_priority = prio_ff[0];
            end
         end
      end
      rsp_in.occupancy = to_occupancy(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         tick_ff     <= '0;
         interval_ff <= INTERVAL_RESET;
      end else begin
         if (cmd.exec) begin
            count_ff <= count_in;
            tick_ff  <= tick_in;
         end
         if (csr_wr_en) interval_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         id_ff   <= id_in;
         kind_ff <= kind_in;
         prio_ff <= prio_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ----- src/pjq_checker.sv -----
// ----------------------------------------------------------------------------
// pjq_checker
// Port-level checks of the priority job queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_job_queue_macros.svh"

module pjq_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire pjq_pkg::req_payload_type req_payload,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire pjq_pkg::rsp_payload_type rsp_payload
);
   import pjq_pkg::*;

   logic no_job;
   logic job_zero;
   logic is_full;
   assign no_job = (rsp_payload.status == ST_FULL) || (rsp_payload.status == ST_DUPLICATE)
                || (rsp_payload.status == ST_NOT_FOUND)
                || (rsp_payload.status == ST_REMOVE_EMPTY)
                || (rsp_payload.status == ST_WAITING)
                || (rsp_payload.status == ST_TICK_EMPTY);
   assign job_zero = (rsp_payload.out_id == 16'h0000) && (rsp_payload.out_kind == 2'd0)
                  && (rsp_payload.out_priority == 2'd0);
   assign is_full = (rsp_payload.status == ST_FULL);

   `PJQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `PJQ_ASSERT_NEXT(a_one_result, req_valid && req_ready, rsp_valid)
   `PJQ_ASSERT_NOW(a_occ_bound, rsp_valid, rsp_payload.occupancy <= 5'(QUEUE_DEPTH))
   `PJQ_ASSERT_NOW(a_no_job_zero, rsp_valid && no_job, job_zero)
   `PJQ_ASSERT_NOW(a_full_occ, rsp_valid && is_full, rsp_payload.occupancy == 5'(QUEUE_DEPTH))

endmodule

bind priority_job_queue pjq_checker u_pjq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
